// ===== src/cesc_pkg.sv =====
// Package for the clock edge setup constraint unit.
// Holds sizes, status codes and the command and status structs between
// controller and datapath. No dependencies.
package cesc_pkg;

	localparam int FIELD_W   = 16;
	localparam int TIME_BITS = 16;
	localparam int MAX_EDGES = 1024;
	localparam int GAP_W     = 27;

	localparam int TW    = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
	localparam int KW    = $clog2(TW);
	localparam int DCW   = $clog2(TW + 1);
	localparam int SUM_W = TW + $clog2(MAX_EDGES);
	localparam int LIM_W = 18;
	localparam int CMP_W = (SUM_W > GAP_W) ? SUM_W : GAP_W;

	localparam logic [GAP_W-1:0] GAP_ONES = '1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOGAP   = 2'd1,
		ST_TOOMANY = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic gcd_step;
		logic div_init;
		logic div_sel;
		logic div_step;
		logic walk_init;
		logic walk_step;
	} cmd_t;

	typedef struct packed {
		logic quick;
		logic gcd_done;
		logic div_done;
		logic too_many;
		logic walk_done;
	} sts_t;

	typedef struct packed {
		logic in_ready;
		logic emit;
	} hs_t;

endpackage

// ===== src/cesc_if.sv =====
// Valid/ready channel interfaces for the clock edge setup constraint unit.
// Input channel carries a clock pair, output channel carries gap and status.
// No dependencies.
interface cesc_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] src_period;
	logic [15:0] src_offset;
	logic [15:0] dst_period;
	logic [15:0] dst_offset;

	modport source (output valid, src_period, src_offset, dst_period, dst_offset,
		input ready);
	modport sink (input valid, src_period, src_offset, dst_period, dst_offset,
		output ready);
endinterface

interface cesc_out_if;
	logic        valid;
	logic        ready;
	logic [26:0] setup_gap;
	logic [1:0]  status;

	modport source (output valid, setup_gap, status, input ready);
	modport sink (input valid, setup_gap, status, output ready);
endinterface

// ===== src/cesc_dp.sv =====
// Datapath: binary GCD, shared restoring divider and the edge merge walk.
// Driven by cesc_ctrl through cmd_t; depends on cesc_pkg.
module cesc_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cesc_pkg::cmd_t                cmd,
	input  logic [cesc_pkg::TW-1:0]       sp_in,
	input  logic [cesc_pkg::TW-1:0]       so_in,
	input  logic [cesc_pkg::TW-1:0]       dp_in,
	input  logic [cesc_pkg::TW-1:0]       dq_in,
	output cesc_pkg::sts_t                sts,
	output logic [cesc_pkg::GAP_W-1:0]    gap,
	output cesc_pkg::status_t             status
);

	logic [cesc_pkg::TW-1:0]    sp_q, so_q, dp_q, dq_q;
	logic [cesc_pkg::TW-1:0]    a_q, b_q;
	logic [cesc_pkg::KW-1:0]    k_q;
	logic [cesc_pkg::TW-1:0]    rem_q, quo_q, ns_last_q;
	logic [cesc_pkg::DCW-1:0]   cnt_q;
	logic [cesc_pkg::SUM_W-1:0] s_q, t_q;
	logic [cesc_pkg::TW-1:0]    i_q, j_q;
	logic [cesc_pkg::GAP_W-1:0] best_q, quick_gap_q;
	cesc_pkg::status_t          quick_st_q;
	logic                       quick_q, found_q, walk_done_q;

	logic [cesc_pkg::TW-1:0]    g;
	logic [cesc_pkg::TW:0]      rem_sh, rem_nx;
	logic                       rem_ge;
	logic                       ident, zero_per;
	logic                       gcd_done, div_done, too_many;
	logic                       t_le_s;
	logic [cesc_pkg::SUM_W-1:0] diff;
	logic [cesc_pkg::CMP_W-1:0] diff_c;
	logic [cesc_pkg::GAP_W-1:0] gap_v;

	assign g        = a_q << k_q;
	assign gcd_done = (a_q == b_q);
	assign div_done = (cnt_q == cesc_pkg::DCW'(cesc_pkg::TW));
	assign rem_sh   = {rem_q, quo_q[cesc_pkg::TW-1]};
	assign rem_ge   = (rem_sh >= {1'b0, g});
	assign rem_nx   = rem_ge ? (rem_sh - {1'b0, g}) : rem_sh;
	assign too_many = (cesc_pkg::LIM_W'(ns_last_q) >= cesc_pkg::LIM_W'(cesc_pkg::MAX_EDGES))
		|| (cesc_pkg::LIM_W'(quo_q) >= cesc_pkg::LIM_W'(cesc_pkg::MAX_EDGES));

	assign ident    = (sp_in == dp_in) && (so_in == dq_in);
	assign zero_per = (sp_in == '0) || (dp_in == '0);

	assign t_le_s = (t_q <= s_q);
	assign diff   = t_q - s_q;
	assign diff_c = cesc_pkg::CMP_W'(diff);
	assign gap_v  = (diff_c >= cesc_pkg::CMP_W'(cesc_pkg::GAP_ONES))
		? (cesc_pkg::GAP_ONES - cesc_pkg::GAP_W'(1)) : diff_c[cesc_pkg::GAP_W-1:0];

	always_comb begin
		sts.quick     = quick_q;
		sts.gcd_done  = gcd_done;
		sts.div_done  = div_done;
		sts.too_many  = too_many;
		sts.walk_done = walk_done_q;
	end

	always_comb begin
		priority if (quick_q) begin
			gap    = quick_gap_q;
			status = quick_st_q;
		end else if (too_many) begin
			gap    = cesc_pkg::GAP_ONES;
			status = cesc_pkg::ST_TOOMANY;
		end else if (found_q) begin
			gap    = best_q;
			status = cesc_pkg::ST_OK;
		end else begin
			gap    = cesc_pkg::GAP_ONES;
			status = cesc_pkg::ST_NOGAP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quick_q     <= 1'b0;
			found_q     <= 1'b0;
			walk_done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				quick_q <= ident || zero_per;
				found_q <= 1'b0;
			end
			if (cmd.walk_init) begin
				found_q     <= 1'b0;
				walk_done_q <= 1'b0;
			end else if (cmd.walk_step && !walk_done_q) begin
				if (t_le_s) begin
					if (j_q == quo_q) begin
						walk_done_q <= 1'b1;
					end
				end else begin
					found_q <= 1'b1;
					if (i_q == ns_last_q) begin
						walk_done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sp_q        <= sp_in;
			so_q        <= so_in;
			dp_q        <= dp_in;
			dq_q        <= dq_in;
			a_q         <= sp_in;
			b_q         <= dp_in;
			k_q         <= '0;
			quick_gap_q <= ident ? cesc_pkg::GAP_W'(sp_in) : cesc_pkg::GAP_ONES;
			quick_st_q  <= ident ? cesc_pkg::ST_OK : cesc_pkg::ST_NOGAP;
		end else if (cmd.gcd_step) begin
			priority if (a_q == b_q) begin
				a_q <= a_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + cesc_pkg::KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= (a_q - b_q) >> 1;
			end else begin
				b_q <= (b_q - a_q) >> 1;
			end
		end

		if (cmd.div_init) begin
			rem_q <= '0;
			cnt_q <= '0;
			quo_q <= cmd.div_sel ? sp_q : dp_q;
			if (cmd.div_sel) begin
				ns_last_q <= quo_q;
			end
		end else if (cmd.div_step && !div_done) begin
			rem_q <= rem_nx[cesc_pkg::TW-1:0];
			quo_q <= {quo_q[cesc_pkg::TW-2:0], rem_ge};
			cnt_q <= cnt_q + cesc_pkg::DCW'(1);
		end

		if (cmd.walk_init) begin
			s_q <= cesc_pkg::SUM_W'(so_q);
			t_q <= cesc_pkg::SUM_W'(dq_q);
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.walk_step && !walk_done_q) begin
			if (t_le_s) begin
				if (j_q != quo_q) begin
					j_q <= j_q + cesc_pkg::TW'(1);
					t_q <= t_q + cesc_pkg::SUM_W'(dp_q);
				end
			end else begin
				if (!found_q || gap_v < best_q) begin
					best_q <= gap_v;
				end
				if (i_q != ns_last_q) begin
					i_q <= i_q + cesc_pkg::TW'(1);
					s_q <= s_q + cesc_pkg::SUM_W'(sp_q);
				end
			end
		end
	end

endmodule

// ===== src/cesc_ctrl.sv =====
// Controller: sequences load, GCD, the two divisions, the edge walk and
// result hand-off. Depends on cesc_pkg; drives cesc_dp through cmd_t.
module cesc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           out_free,
	input  cesc_pkg::sts_t sts,
	output cesc_pkg::cmd_t cmd,
	output cesc_pkg::hs_t  hs
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_GCD,
		S_DIVD_INIT,
		S_DIVD,
		S_DIVS_INIT,
		S_DIVS,
		S_WALK_INIT,
		S_WALK,
		S_FIN
	} state_t;

	state_t state_q;

	always_comb begin
		cmd          = '0;
		hs.in_ready  = (state_q == S_IDLE);
		hs.emit      = (state_q == S_FIN) && out_free;
		cmd.load     = hs.in_ready && in_valid;
		unique case (state_q)
			S_GCD:       cmd.gcd_step = 1'b1;
			S_DIVD_INIT: cmd.div_init = 1'b1;
			S_DIVD:      cmd.div_step = 1'b1;
			S_DIVS_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_sel  = 1'b1;
			end
			S_DIVS:      cmd.div_step  = 1'b1;
			S_WALK_INIT: cmd.walk_init = 1'b1;
			S_WALK:      cmd.walk_step = 1'b1;
			default:     cmd.gcd_step  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: state_q <= sts.quick ? S_FIN : S_GCD;
				S_GCD: begin
					if (sts.gcd_done) state_q <= S_DIVD_INIT;
				end
				S_DIVD_INIT: state_q <= S_DIVD;
				S_DIVD: begin
					if (sts.div_done) state_q <= S_DIVS_INIT;
				end
				S_DIVS_INIT: state_q <= S_DIVS;
				S_DIVS: begin
					if (sts.div_done) state_q <= sts.too_many ? S_FIN : S_WALK_INIT;
				end
				S_WALK_INIT: state_q <= S_WALK;
				S_WALK: begin
					if (sts.walk_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_load_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CHECK)
		else $error("load did not move to check");

	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hs.emit |=> state_q == S_IDLE)
		else $error("emit did not return to idle");

	a_ready_emit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(hs.in_ready && hs.emit))
		else $error("ready and emit together");

	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && sts.walk_done) |=> state_q == S_FIN)
		else $error("walk end not followed by result");

endmodule

// ===== src/clock_edge_setup_constraint_unit.sv =====
// Top level of the clock edge setup constraint unit: channels, controller,
// datapath and the output register. Depends on cesc_pkg, cesc_if,
// cesc_ctrl and cesc_dp.
//
// Usage: each item on item_in carries a source and a sink clock (period and
// first rising edge offset). One item comes out on item_out per item in,
// with the smallest positive sink-minus-source edge gap and a status.
// Items are handled one at a time; item_in.ready is high only while the
// controller is idle.
// Processing: identical clocks or a zero period go straight to the result.
// Otherwise the unit runs G binary GCD steps (at most 2 x 16), two divisions
// and W merge walk steps (at most source edges plus sink edges, so up to
// 2 x MAX_EDGES). The walk handles one edge a cycle.
// Too many edges skips the walk.
// The result sits in an output register, so the next item is accepted
// while it waits. If the receiver stalls and a second result is ready, the
// controller holds it until the register frees.
// Reset (arst_n low) returns the controller to idle and empties the output.
module clock_edge_setup_constraint_unit (
	input  logic        clk,
	input  logic        arst_n,
	cesc_in_if.sink     item_in,
	cesc_out_if.source  item_out
);

	cesc_pkg::cmd_t             cmd;
	cesc_pkg::sts_t             sts;
	cesc_pkg::hs_t              hs;
	cesc_pkg::status_t          res_status;
	logic [cesc_pkg::GAP_W-1:0] res_gap;
	logic [cesc_pkg::GAP_W-1:0] gap_q;
	logic [1:0]                 status_q;
	logic                       out_vld_q;
	logic                       out_free;

	assign out_free      = !out_vld_q || item_out.ready;
	assign item_in.ready = hs.in_ready;

	cesc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_in.valid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.hs       (hs)
	);

	cesc_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sp_in  (item_in.src_period[cesc_pkg::TW-1:0]),
		.so_in  (item_in.src_offset[cesc_pkg::TW-1:0]),
		.dp_in  (item_in.dst_period[cesc_pkg::TW-1:0]),
		.dq_in  (item_in.dst_offset[cesc_pkg::TW-1:0]),
		.sts    (sts),
		.gap    (res_gap),
		.status (res_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (hs.emit) begin
			out_vld_q <= 1'b1;
		end else if (item_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hs.emit) begin
			gap_q    <= res_gap;
			status_q <= res_status;
		end
	end

	assign item_out.valid     = out_vld_q;
	assign item_out.setup_gap = gap_q;
	assign item_out.status    = status_q;

endmodule
